@@ rtl/mddt_pkg.sv @@
package mddt_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int COUNT_BITS    = 16;
   localparam int KEY_BITS      = 32;
   localparam int TOTAL_BITS    = $clog2(TABLE_ENTRIES + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                       eval;
      logic                       commit;
      logic                       cmd;
      logic                       new_key;
      logic signed [KEY_BITS-1:0] key;
   } cell_ctrl_type;

   // per-cell status back to the controller
   typedef struct packed {
      logic free;
      logic hit;
      logic sat;
      logic count_one;
      logic count_two;
   } cell_status_type;

endpackage

@@ rtl/mddt_channels.sv @@
interface mddt_req_if;
   import mddt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic signed [KEY_BITS-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface mddt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] set_class;
   logic       table_full;
   logic       count_saturated;

   modport source (output valid, output set_class, output table_full,
                   output count_saturated, input ready);
   modport sink   (input valid, input set_class, input table_full,
                   input count_saturated, output ready);
endinterface

@@ rtl/mddt_cell.sv @@
module mddt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  mddt_pkg::cell_ctrl_type   ctrl,
   input  logic                      claim,
   output mddt_pkg::cell_status_type status
);
   import mddt_pkg::*;

   logic signed [KEY_BITS-1:0] key_ff,   key_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic                       valid_ff, valid_in;
   logic                       match_ff, match_in;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctrl.eval) begin
         match_in = valid_ff && (key_ff == ctrl.key);
      end
      if (ctrl.commit) begin
         match_in = 1'b0;
         if (ctrl.cmd == CMD_INSERT) begin
            if (match_ff && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + COUNT_ONE;
            end else if (ctrl.new_key && claim) begin
               key_in   = ctrl.key;
               count_in = COUNT_ONE;
               valid_in = 1'b1;
            end
         end else if (match_ff) begin
            count_in = count_ff - COUNT_ONE;
            // last occurrence gone: free the cell
            if (count_ff == COUNT_ONE) begin
               valid_in = 1'b0;
               key_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   assign status.free      = ~valid_ff;
   assign status.hit       = match_ff;
   assign status.sat       = match_ff && (count_ff == COUNT_MAX);
   assign status.count_one = match_ff && (count_ff == COUNT_ONE);
   assign status.count_two = match_ff && (count_ff == COUNT_TWO);

endmodule

@@ rtl/multiset_duplicate_distinct_tracker.sv @@
// A transaction is matched in every cell as it is accepted and committed once the result slot
//   is free; the commit raises its result on rsp_chan.
// The compare/commit pair over the shared row of cells keeps a new transaction out until the
//   current one commits; a result held by rsp_chan stalls the commit.
// Reset (synchronous, active high) clears every cell's key, count and valid bit and both
//   totals; no clearing pass is needed.
module multiset_duplicate_distinct_tracker (
   input  logic       clock,
   input  logic       reset,
   mddt_req_if.sink   req_chan,
   mddt_rsp_if.source rsp_chan
);
   import mddt_pkg::*;

   typedef enum logic [0:0] {
      ST_MATCH,   // idle; accept a transaction and launch the compare in every cell
      ST_COMMIT   // apply the update once the result slot is free
   } state_type;

   state_type                  state_ff;
   logic                       cmd_ff;
   logic signed [KEY_BITS-1:0] key_ff;

   logic [TOTAL_BITS-1:0] distinct_ff, distinct_in;
   logic [TOTAL_BITS-1:0] duplicate_ff, duplicate_in;

   logic       rsp_valid_ff;
   logic [1:0] rsp_class_ff;
   logic       rsp_full_ff;
   logic       rsp_sat_ff;

   cell_ctrl_type   ctrl;
   cell_status_type status [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] free_vec, hit_vec, sat_vec, one_vec, two_vec;
   logic [TABLE_ENTRIES-1:0] claim_ff, claim_in;
   logic                     any_free_ff;

   logic accept, commit;
   logic hit_any, sat_any, one_any, two_any;
   logic is_insert, new_key, full_flag, sat_flag;

   assign accept = req_chan.valid && req_chan.ready;
   // commit when the output slot is empty or is being drained this cycle
   assign commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == ST_MATCH);

   // collect status from the row of cells
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         free_vec[i] = status[i].free;
         hit_vec[i]  = status[i].hit;
         sat_vec[i]  = status[i].sat;
         one_vec[i]  = status[i].count_one;
         two_vec[i]  = status[i].count_two;
      end
   end

   // isolate the lowest free cell: x & (~x + 1)
   assign claim_in = free_vec & (~free_vec + TABLE_ENTRIES'(1));

   assign hit_any = |hit_vec;
   assign sat_any = |sat_vec;
   assign one_any = |one_vec;
   assign two_any = |two_vec;

   assign is_insert = (cmd_ff == CMD_INSERT);
   assign new_key   = is_insert && !hit_any;
   assign full_flag = new_key && !any_free_ff;
   assign sat_flag  = is_insert && sat_any;

   // the compare uses the live request key; the update uses the held one
   assign ctrl.eval    = accept;
   assign ctrl.commit  = commit;
   assign ctrl.cmd     = cmd_ff;
   assign ctrl.new_key = new_key;
   assign ctrl.key     = accept ? req_chan.key : key_ff;

   genvar g;
   generate
      for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
         mddt_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .claim  (claim_ff[g]),
            .status (status[g])
         );
      end
   endgenerate

   // running totals after this transaction
   always_comb begin
      distinct_in  = distinct_ff;
      duplicate_in = duplicate_ff;
      if (is_insert) begin
         if (hit_any) begin
            if (!sat_any && one_any) begin
               duplicate_in = duplicate_ff + TOTAL_BITS'(1);
            end
         end else if (any_free_ff) begin
            distinct_in = distinct_ff + TOTAL_BITS'(1);
         end
      end else if (hit_any) begin
         if (two_any) begin
            duplicate_in = duplicate_ff - TOTAL_BITS'(1);
         end
         if (one_any) begin
            distinct_in = distinct_ff - TOTAL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_chan.cmd;
         key_ff      <= req_chan.key;
         any_free_ff <= |free_vec;
      end
      if (commit) begin
         rsp_class_ff <= {distinct_in > TOTAL_BITS'(1), duplicate_in != '0};
         rsp_full_ff  <= full_flag;
         rsp_sat_ff   <= sat_flag;
      end
      if (reset) begin
         state_ff     <= ST_MATCH;
         rsp_valid_ff <= 1'b0;
         distinct_ff  <= '0;
         duplicate_ff <= '0;
         claim_ff     <= '0;
      end else begin
         case (state_ff)
            ST_MATCH: begin
               if (rsp_valid_ff && rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  claim_ff <= claim_in;
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit) begin
                  distinct_ff  <= distinct_in;
                  duplicate_ff <= duplicate_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_MATCH;
               end
            end
            default: begin
               state_ff <= ST_MATCH;
            end
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.set_class       = rsp_class_ff;
   assign rsp_chan.table_full      = rsp_full_ff;
   assign rsp_chan.count_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   // keys are unique in the table, so at most one cell matches
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> $onehot0(hit_vec))
      else $error("more than one cell matched the key");

   a_single_claim: assert property (@(posedge clock) disable iff (reset)
      $onehot0(claim_ff))
      else $error("more than one cell claimed for a new key");

   a_distinct_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> (32'(distinct_ff) == 32'($countones(~free_vec))))
      else $error("distinct total disagrees with occupied cells");

   a_dup_le_distinct: assert property (@(posedge clock) disable iff (reset)
      duplicate_ff <= distinct_ff)
      else $error("duplicate total exceeds distinct total");

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("response raised without a commit");
`endif

endmodule
